FILE: sv/cmfs_pkg.sv
// Cube map face select: shared types and constants.
// No dependencies; imported by every module of the block.
package cmfs_pkg;

  // face codes
  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  localparam int FACE_W = 3;
  localparam int TEX_W  = 16;

  // output beat layout
  localparam int FACE_LSB = 0;
  localparam int U_LSB    = FACE_LSB + FACE_W;
  localparam int V_LSB    = U_LSB + TEX_W;
  localparam int ZERO_BIT = V_LSB + TEX_W;
  localparam int OUT_W    = ((ZERO_BIT + 1 + 7) / 8) * 8;

  // sideband that rides along with the divider lanes
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic              zero;
  } cmfs_side_t;

endpackage

FILE: sv/cmfs_select.sv
// Cube map face select: magnitude stage and major-axis/face selection stage.
// Depends on cmfs_pkg. Feeds numerators and denominator to cmfs_divide.
module cmfs_select #(
  parameter int DW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] in_x,
  input  logic signed [DW-1:0] in_y,
  input  logic signed [DW-1:0] in_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cmfs_pkg::cmfs_side_t out_side,
  output logic [DW:0]          out_num_u,
  output logic [DW:0]          out_num_v,
  output logic [DW:0]          out_den
);
  import cmfs_pkg::*;

  localparam int WD = DW + 1;

  // ma +/- c, known to land in [0, 2*ma]
  function automatic logic [WD-1:0] offset(logic [DW-1:0] ma, logic signed [DW-1:0] c,
                                           logic neg);
    logic signed [DW+1:0] me;
    logic signed [DW+1:0] ce;
    logic signed [DW+1:0] sum;
    me  = signed'({2'b00, ma});
    ce  = DW'(c) == '0 ? '0 : {{2{c[DW-1]}}, c};
    sum = neg ? me - ce : me + ce;
    return sum[WD-1:0];
  endfunction

  // stage A: magnitudes
  logic                 a_valid;
  logic signed [DW-1:0] a_x, a_y, a_z;
  logic [DW-1:0]        a_ax, a_ay, a_az;
  logic                 en_a;

  // stage B: selection
  logic                 b_valid;
  logic                 en_b;

  logic [DW-1:0] ax_c, ay_c, az_c;
  assign ax_c = in_x[DW-1] ? DW'(-in_x) : DW'(in_x);
  assign ay_c = in_y[DW-1] ? DW'(-in_y) : DW'(in_y);
  assign az_c = in_z[DW-1] ? DW'(-in_z) : DW'(in_z);

  assign en_b     = !b_valid || out_ready;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_x  <= in_x;
      a_y  <= in_y;
      a_z  <= in_z;
      a_ax <= ax_c;
      a_ay <= ay_c;
      a_az <= az_c;
    end
  end

  cmfs_side_t    side_next;
  logic [DW-1:0] ma;
  logic [WD-1:0] num_u_next, num_v_next;
  logic          pick_z, pick_y;

  // z wins ties against both, y wins ties against x
  assign pick_z = (a_az >= a_ax) && (a_az >= a_ay);
  assign pick_y = (a_ay >= a_ax);

  always_comb begin
    side_next.zero = (a_ax == '0) && (a_ay == '0) && (a_az == '0);
    if (pick_z) begin
      ma = a_az;
      side_next.face = a_z[DW-1] ? FACE_NZ : FACE_PZ;
      num_u_next     = offset(a_az, a_x, a_z[DW-1]);
      num_v_next     = offset(a_az, a_y, 1'b1);
    end else if (pick_y) begin
      ma = a_ay;
      side_next.face = a_y[DW-1] ? FACE_NY : FACE_PY;
      num_u_next     = offset(a_ay, a_x, 1'b0);
      num_v_next     = offset(a_ay, a_z, a_y[DW-1]);
    end else begin
      ma = a_ax;
      side_next.face = a_x[DW-1] ? FACE_NX : FACE_PX;
      num_u_next     = offset(a_ax, a_z, !a_x[DW-1]);
      num_v_next     = offset(a_ax, a_y, 1'b1);
    end
    if (side_next.zero) begin
      side_next.face = FACE_PX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_valid) begin
      out_side  <= side_next;
      out_num_u <= num_u_next;
      out_num_v <= num_v_next;
      out_den   <= {ma, 1'b0};
    end
  end

  assign out_valid = b_valid;

endmodule

FILE: sv/cmfs_divide.sv
// Cube map face select: pipelined restoring divider, one quotient bit per stage,
// two lanes (u, v) sharing one denominator, plus saturation and output register.
// Depends on cmfs_pkg.
module cmfs_divide #(
  parameter int DW = 16,
  parameter int F  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cmfs_pkg::cmfs_side_t         in_side,
  input  logic [DW:0]                  in_num_u,
  input  logic [DW:0]                  in_num_v,
  input  logic [DW:0]                  in_den,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cmfs_pkg::cmfs_side_t         out_side,
  output logic [cmfs_pkg::TEX_W-1:0]   out_u,
  output logic [cmfs_pkg::TEX_W-1:0]   out_v
);
  import cmfs_pkg::*;

  localparam int WD = DW + 1;
  localparam int NS = F + 1;
  localparam int QW = (F > TEX_W) ? F : TEX_W;
  localparam logic [F-1:0] HALF = {1'b1, {(F-1){1'b0}}};

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [WD:0] div_step(logic [WD-1:0] r, logic [WD-1:0] d);
    logic [WD:0] r2;
    logic [WD:0] diff;
    r2   = {r, 1'b0};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      return {1'b1, diff[WD-1:0]};
    end else begin
      return {1'b0, r2[WD-1:0]};
    end
  endfunction

  function automatic logic [TEX_W-1:0] to_tex(logic [F-1:0] q);
    logic [QW-1:0] w;
    w = QW'(q);
    return w[TEX_W-1:0];
  endfunction

  logic [NS-1:0]   sv;
  logic [NS-1:0]   sqi_u, sqi_v;
  logic [WD-1:0]   sr_u [NS];
  logic [WD-1:0]   sr_v [NS];
  logic [F-1:0]    sq_u [NS];
  logic [F-1:0]    sq_v [NS];
  logic [WD-1:0]   sden [NS];
  cmfs_side_t      sside [NS];
  logic [NS:0]     en;
  logic            o_valid;

  assign en[NS]   = !o_valid || out_ready;
  assign in_ready = en[0];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_en
      assign en[k] = !sv[k] || en[k+1];
    end
  endgenerate

  // stage 0: integer bit; set only when numerator equals denominator
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en[0]) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      sqi_u[0] <= (in_num_u >= in_den);
      sqi_v[0] <= (in_num_v >= in_den);
      sr_u[0]  <= (in_num_u >= in_den) ? in_num_u - in_den : in_num_u;
      sr_v[0]  <= (in_num_v >= in_den) ? in_num_v - in_den : in_num_v;
      sq_u[0]  <= '0;
      sq_v[0]  <= '0;
      sden[0]  <= in_den;
      sside[0] <= in_side;
    end
  end

  // stages 1..F: one fraction bit each
  generate
    for (k = 1; k < NS; k++) begin : g_stage
      logic [WD:0] step_u, step_v;
      assign step_u = div_step(sr_u[k-1], sden[k-1]);
      assign step_v = div_step(sr_v[k-1], sden[k-1]);

      always_ff @(posedge clk) begin
        if (rst) begin
          sv[k] <= 1'b0;
        end else if (en[k]) begin
          sv[k] <= sv[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[k] && sv[k-1]) begin
          sqi_u[k] <= sqi_u[k-1];
          sqi_v[k] <= sqi_v[k-1];
          sr_u[k]  <= step_u[WD-1:0];
          sr_v[k]  <= step_v[WD-1:0];
          sq_u[k]  <= {sq_u[k-1][F-2:0], step_u[WD]};
          sq_v[k]  <= {sq_v[k-1][F-2:0], step_v[WD]};
          sden[k]  <= sden[k-1];
          sside[k] <= sside[k-1];
        end
      end
    end
  endgenerate

  // output register: zero vector and the +ma edge case (saturate)
  logic [F-1:0] fin_u, fin_v;
  always_comb begin
    if (sside[NS-1].zero) begin
      fin_u = HALF;
      fin_v = HALF;
    end else begin
      fin_u = sqi_u[NS-1] ? '1 : sq_u[NS-1];
      fin_v = sqi_v[NS-1] ? '1 : sq_v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en[NS]) begin
      o_valid <= sv[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS] && sv[NS-1]) begin
      out_side <= sside[NS-1];
      out_u    <= to_tex(fin_u);
      out_v    <= to_tex(fin_v);
    end
  end

  assign out_valid = o_valid;

endmodule

FILE: sv/cube_map_face_select_top.sv
// Cube map face select, top level: stream ports around cmfs_select and cmfs_divide.
// Depends on cmfs_pkg, cmfs_select, cmfs_divide.
//
// Takes one direction vector per beat and returns the cube face (+X 0, -X 1, +Y 2,
// -Y 3, +Z 4, -Z 5) plus u, v in unsigned Q0.UV_FRAC_BITS, u = (sc/ma + 1)/2, rounded
// down, with the +ma edge clamped to all ones. A zero vector returns face +X,
// u = v = one half and the zero_vector flag. The block takes one beat per cycle while
// m_tready is high and returns results in order. The pipeline holds two stages for
// magnitudes and face selection, UV_FRAC_BITS + 1 restoring divider stages that each
// resolve one quotient bit, and the output register. Backpressure collapses bubbles,
// so s_tready stays high while m_tready is high.
module cube_map_face_select_top #(
  parameter int DIR_WIDTH    = 16,
  parameter int UV_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // dir_x, dir_y, dir_z (DIR_WIDTH each, signed), zero pad
  input  logic [((3*DIR_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // face_index[2:0], tex_u[18:3], tex_v[34:19], zero_vector[35], zero pad
  output logic [cmfs_pkg::OUT_W-1:0]           m_tdata
);
  import cmfs_pkg::*;

  localparam int DW = DIR_WIDTH;

  logic                 sel_valid, sel_ready;
  cmfs_side_t           sel_side;
  logic [DW:0]          sel_num_u, sel_num_v, sel_den;
  cmfs_side_t           div_side;
  logic [TEX_W-1:0]     div_u, div_v;

  cmfs_select #(.DW(DW)) u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (signed'(s_tdata[DW-1:0])),
    .in_y      (signed'(s_tdata[2*DW-1:DW])),
    .in_z      (signed'(s_tdata[3*DW-1:2*DW])),
    .out_valid (sel_valid),
    .out_ready (sel_ready),
    .out_side  (sel_side),
    .out_num_u (sel_num_u),
    .out_num_v (sel_num_v),
    .out_den   (sel_den)
  );

  cmfs_divide #(.DW(DW), .F(UV_FRAC_BITS)) u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_side   (sel_side),
    .in_num_u  (sel_num_u),
    .in_num_v  (sel_num_v),
    .in_den    (sel_den),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_side  (div_side),
    .out_u     (div_u),
    .out_v     (div_v)
  );

  always_comb begin
    m_tdata                            = '0;
    m_tdata[FACE_LSB +: FACE_W]        = div_side.face;
    m_tdata[U_LSB +: TEX_W]            = div_u;
    m_tdata[V_LSB +: TEX_W]            = div_v;
    m_tdata[ZERO_BIT]                  = div_side.zero;
  end

endmodule

FILE: sv/cmfs_checker.sv
// Cube map face select: port-level checker and its bind to the top level.
// Depends on cmfs_pkg and cube_map_face_select_top.
module cmfs_checker #(
  parameter int DIR_WIDTH    = 16,
  parameter int UV_FRAC_BITS = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [((3*DIR_WIDTH+7)/8)*8-1:0] s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [cmfs_pkg::OUT_W-1:0]       m_tdata
);
  import cmfs_pkg::*;

  localparam logic [TEX_W-1:0] HALF_TEX =
    (UV_FRAC_BITS > TEX_W) ? '0 : TEX_W'(1 << (UV_FRAC_BITS - 1));

  logic in_beat;
  assign in_beat = s_tvalid && s_tready;

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a stalled output beat stays put, valid and data alike
  a_beat_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat dropped or changed while stalled");

  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled with downstream ready");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[ZERO_BIT] |->
      m_tdata[FACE_LSB +: FACE_W] == FACE_PX &&
      m_tdata[U_LSB +: TEX_W] == HALF_TEX &&
      m_tdata[V_LSB +: TEX_W] == HALF_TEX)
    else $error("zero vector result malformed");

  a_in_beat_known: assert property (@(posedge clk) disable iff (rst)
    in_beat |-> !$isunknown(s_tdata))
    else $error("input beat carries unknown data");

endmodule

bind cube_map_face_select_top cmfs_checker #(
  .DIR_WIDTH    (DIR_WIDTH),
  .UV_FRAC_BITS (UV_FRAC_BITS)
) u_cmfs_checker (.*);

FILE: bench/tb_cube_map_face_select_top.sv
// Self-checking bench for cube_map_face_select_top: directed table, then random vectors.
// Depends on cmfs_pkg and the block's RTL; every result is checked in order against a
// directed table value or the in-bench face/uv predictor, under random idle on both stream sides.
module tb_cube_map_face_select_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cmfs_pkg::*;

  localparam int DIR_W        = 16;
  localparam int UV_FRAC      = 16;
  localparam int IN_W         = ((3 * DIR_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CALM_ITEMS   = 150;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_DIRECTED = 21;
  localparam int MAX_PRINTS   = 30;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [TEX_W-1:0]  u;
    logic [TEX_W-1:0]  v;
    logic              zero;
  } face_uv_t;

  typedef struct {
    int       x;
    int       y;
    int       z;
    bit       known;
    face_uv_t want;
  } dir_row_t;

  localparam face_uv_t NO_WANT = '{FACE_PX, 16'd0, 16'd0, 1'b0};

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  dir_row_t pending_q[$];
  face_uv_t expected_q[$];
  int       mismatch_count = 0;
  int       results_seen   = 0;
  int       accepted_count = 0;
  int       face_hits[6];
  bit       calm     = 1'b0;
  bit       hold_req = 1'b0;
  int       holds_done = 0;

  // known rows: zero vector, most negative axes, clamps, ties
  dir_row_t directed_rows[NUM_DIRECTED] = '{
    '{0, 0, 0, 1'b1, '{FACE_PX, 16'd32768, 16'd32768, 1'b1}},
    '{32767, 0, 0, 1'b0, NO_WANT},
    '{-32768, 0, 0, 1'b1, '{FACE_NX, 16'd32768, 16'd32768, 1'b0}},
    '{0, 32767, 0, 1'b0, NO_WANT},
    '{0, -32768, 0, 1'b1, '{FACE_NY, 16'd32768, 16'd32768, 1'b0}},
    '{0, 0, 32767, 1'b0, NO_WANT},
    '{0, 0, -32768, 1'b1, '{FACE_NZ, 16'd32768, 16'd32768, 1'b0}},
    '{-32768, -32768, -32768, 1'b1, '{FACE_NZ, 16'd65535, 16'd65535, 1'b0}},
    '{32767, 32767, 32767, 1'b1, '{FACE_PZ, 16'd65535, 16'd0, 1'b0}},
    '{100, -100, 0, 1'b1, '{FACE_NY, 16'd65535, 16'd32768, 1'b0}},
    '{-100, 100, 0, 1'b1, '{FACE_PY, 16'd0, 16'd32768, 1'b0}},
    '{100, 50, -100, 1'b1, '{FACE_NZ, 16'd0, 16'd16384, 1'b0}},
    '{1000, -3, 7, 1'b0, NO_WANT},
    '{-1000, 3, -7, 1'b0, NO_WANT},
    '{1, 0, 0, 1'b1, '{FACE_PX, 16'd32768, 16'd32768, 1'b0}},
    '{0, 0, 1, 1'b0, NO_WANT},
    '{-1, -1, 0, 1'b1, '{FACE_NY, 16'd0, 16'd32768, 1'b0}},
    '{12345, -23456, 30000, 1'b0, NO_WANT},
    '{-32768, 32767, -5, 1'b0, NO_WANT},
    '{0, -32768, 32767, 1'b0, NO_WANT},
    '{32767, -32768, 0, 1'b0, NO_WANT}
  };

  cube_map_face_select_top #(
    .DIR_WIDTH   (DIR_W),
    .UV_FRAC_BITS(UV_FRAC)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // generous bound: worst case is far below this
  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // floor((c + ma) * 2^UV_FRAC / (2 * ma)), clamped at all ones
  function automatic logic [TEX_W-1:0] unit_coord(input int c, input int ma);
    longint q;
    q = (longint'(c + ma) <<< UV_FRAC) / (2 * longint'(ma));
    if (q > (longint'(1) <<< UV_FRAC) - 1) q = (longint'(1) <<< UV_FRAC) - 1;
    return q[TEX_W-1:0];
  endfunction

  function automatic face_uv_t predict_face_uv(input int x, input int y, input int z);
    int       ax, ay, az, ma, sc, tc;
    face_uv_t r;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    r.zero = 1'b0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.face = FACE_PX;
      r.u    = TEX_W'(1 << (UV_FRAC - 1));
      r.v    = TEX_W'(1 << (UV_FRAC - 1));
      r.zero = 1'b1;
      return r;
    end
    if (az >= ax && az >= ay) begin
      ma     = az;
      r.face = (z < 0) ? FACE_NZ : FACE_PZ;
      sc     = (z < 0) ? -x : x;
      tc     = -y;
    end else if (ay >= ax) begin
      ma     = ay;
      r.face = (y < 0) ? FACE_NY : FACE_PY;
      sc     = x;
      tc     = (y < 0) ? -z : z;
    end else begin
      ma     = ax;
      r.face = (x < 0) ? FACE_NX : FACE_PX;
      sc     = (x < 0) ? z : -z;
      tc     = -y;
    end
    r.u = unit_coord(sc, ma);
    r.v = unit_coord(tc, ma);
    return r;
  endfunction

  // magnitude m with a random sign; 32768 only exists as negative
  function automatic int signed_mag(input int m);
    if (m == 32768) return -32768;
    return ($urandom_range(0, 1) != 0) ? -m : m;
  endfunction

  function automatic int edge_comp();
    case ($urandom_range(0, 6))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic dir_row_t random_direction();
    dir_row_t r;
    int       m;
    r.known = 1'b0;
    r.want  = NO_WANT;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        r.x = int'($urandom_range(0, 65535)) - 32768;
        r.y = int'($urandom_range(0, 65535)) - 32768;
        r.z = int'($urandom_range(0, 65535)) - 32768;
      end
      4, 5: begin
        // tiny components: ties and the zero vector come up often
        r.x = int'($urandom_range(0, 6)) - 3;
        r.y = int'($urandom_range(0, 6)) - 3;
        r.z = int'($urandom_range(0, 6)) - 3;
      end
      6, 7: begin
        m   = $urandom_range(1, 32768);
        r.x = signed_mag(($urandom_range(0, 1) != 0) ? m : $urandom_range(0, m));
        r.y = signed_mag(($urandom_range(0, 1) != 0) ? m : $urandom_range(0, m));
        r.z = signed_mag(($urandom_range(0, 1) != 0) ? m : $urandom_range(0, m));
      end
      8: begin
        r.x = edge_comp();
        r.y = edge_comp();
        r.z = edge_comp();
      end
      default: begin
        m   = $urandom_range(16, 32768);
        r.x = signed_mag($urandom_range(0, 15));
        r.y = signed_mag($urandom_range(0, 15));
        r.z = signed_mag($urandom_range(0, 15));
        case ($urandom_range(0, 2))
          0:       r.x = signed_mag(m);
          1:       r.y = signed_mag(m);
          default: r.z = signed_mag(m);
        endcase
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  task automatic send_direction(input dir_row_t r);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk);
    end
    pending_q.push_back(r);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({DIR_W'(r.z), DIR_W'(r.y), DIR_W'(r.x)});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // scoreboard: input beats push expectations, output beats pop and compare
  always @(posedge clk) begin : score_beats
    dir_row_t row;
    face_uv_t want;
    face_uv_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        row = pending_q.pop_front();
        want = row.known ? row.want : predict_face_uv(row.x, row.y, row.z);
        expected_q.push_back(want);
        accepted_count++;
      end
      if (m_tvalid && m_tready) begin
        got.face = m_tdata[FACE_LSB +: FACE_W];
        got.u    = m_tdata[U_LSB +: TEX_W];
        got.v    = m_tdata[V_LSB +: TEX_W];
        got.zero = m_tdata[ZERO_BIT];
        if (expected_q.size() == 0) begin
          report_mismatch("beat with nothing pending, face", got.face, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.face !== want.face) report_mismatch("face_index", got.face, want.face);
          if (got.u !== want.u) report_mismatch("tex_u", got.u, want.u);
          if (got.v !== want.v) report_mismatch("tex_v", got.v, want.v);
          if (got.zero !== want.zero) report_mismatch("zero_vector", got.zero, want.zero);
          if (want.face < 6) face_hits[want.face]++;
        end
        results_seen++;
      end
    end
  end

  // output side: random ready, long hold-offs on request, always ready when calm
  initial begin : drain_results
    int run;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        run = $urandom_range(1, 40);
        repeat (run) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        run = $urandom_range(1, 19);
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : drive_directions
    @(posedge clk);
    while (rst) @(posedge clk);
    foreach (directed_rows[i]) send_direction(directed_rows[i]);
    hold_req = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) hold_req = 1'b1;
      calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
      send_direction(random_direction());
    end
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d vectors in (%0d directed), %0d results, %0d receiver hold-offs",
             accepted_count, NUM_DIRECTED, results_seen, holds_done);
    $display("face counts +X %0d -X %0d +Y %0d -Y %0d +Z %0d -Z %0d, %0d mismatches",
             face_hits[0], face_hits[1], face_hits[2], face_hits[3], face_hits[4],
             face_hits[5], mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/cmfs_pkg.sv
sv/cmfs_select.sv
sv/cmfs_divide.sv
sv/cube_map_face_select_top.sv
sv/cmfs_checker.sv
bench/tb_cube_map_face_select_top.sv
